FILE: rtl/fdss_pkg.sv
package fdss_pkg;

    localparam int DATA_W     = 32;
    localparam int RHO_W      = 29;
    localparam int SHIFT_W    = 5;
    localparam int NODE_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int FRAC_BITS  = 28;
    localparam int PROD_W     = DATA_W + RHO_W + 1;

    localparam int NODES_DEF = 64;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TENSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTNODE = 2'd2;

    localparam logic [RHO_W-1:0]   TENSION_RST = 29'd7664016;
    localparam logic [SHIFT_W-1:0] DAMPING_RST = 5'd13;
    localparam logic [NODE_W-1:0]  OUTNODE_RST = 6'd32;

    // Operation select of the shared add/shift unit.
    typedef struct packed {
        logic sub;
        logic shift;
    } alu_ctrl_t;

endpackage

FILE: rtl/fdss_ram.sv
module fdss_ram #(
    parameter int DEPTH = fdss_pkg::NODES_DEF,
    parameter int WIDTH = fdss_pkg::DATA_W
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/fdss_alu.sv
module fdss_alu (
    input  logic [fdss_pkg::DATA_W-1:0]  a,
    input  logic [fdss_pkg::DATA_W-1:0]  b,
    input  fdss_pkg::alu_ctrl_t          ctrl,
    input  logic [fdss_pkg::SHIFT_W-1:0] shamt,
    output logic [fdss_pkg::DATA_W-1:0]  y
);

    import fdss_pkg::*;

    logic [DATA_W-1:0] b_shifted;
    logic [DATA_W-1:0] b_operand;

    // Arithmetic shift keeps the sign of the fix28 word.
    assign b_shifted = ctrl.shift ? DATA_W'($signed(b) >>> shamt) : b;
    assign b_operand = ctrl.sub ? ~b_shifted : b_shifted;
    assign y         = a + b_operand + DATA_W'(ctrl.sub);

endmodule

FILE: rtl/finite_difference_string_synth.sv
// Channel   Handshake                 Payload
// s_        s_valid / s_ready         s_action, s_node_index, s_node_value
// m_        m_valid / m_ready         m_sample
// cfg_      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A load is written into both node memories in the cycle it is taken. In a tick, each
// interior node runs eight steps through the one shared add/shift unit and the multiplier,
// and every other node two, paced by the one read and one write port of each node memory.
// After reset the block sweeps both node memories to zero before it raises s_ready.
// A tick that finishes while its predecessor's sample still waits on m_ holds until it goes.
// Configuration transfers are taken in every cycle.
module finite_difference_string_synth #(
    parameter int NODES = fdss_pkg::NODES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_action,
    input  logic [fdss_pkg::NODE_W-1:0]        s_node_index,
    input  logic signed [fdss_pkg::DATA_W-1:0] s_node_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [fdss_pkg::DATA_W-1:0] m_sample,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fdss_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fdss_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import fdss_pkg::*;

    localparam int AW = $clog2(NODES);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_TSTART = 4'd2;
    localparam logic [3:0] ST_TLOAD  = 4'd3;
    localparam logic [3:0] ST_READ   = 4'd4;
    localparam logic [3:0] ST_DPREV  = 4'd5;
    localparam logic [3:0] ST_SUM    = 4'd6;
    localparam logic [3:0] ST_DIFF   = 4'd7;
    localparam logic [3:0] ST_MUL    = 4'd8;
    localparam logic [3:0] ST_ADDC   = 4'd9;
    localparam logic [3:0] ST_SUBP   = 4'd10;
    localparam logic [3:0] ST_WRITE  = 4'd11;
    localparam logic [3:0] ST_FIN    = 4'd12;

    logic [3:0]        state_reg, state_next;
    logic [AW-1:0]     node_reg, node_next;
    logic [DATA_W-1:0] win_l_reg, win_l_next;
    logic [DATA_W-1:0] win_c_reg, win_c_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] dprev_reg, dprev_next;
    logic [DATA_W-1:0] sample_reg, sample_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_sample_reg, m_sample_next;
    logic [RHO_W-1:0]   tension_reg;
    logic [SHIFT_W-1:0] damping_reg;
    logic [NODE_W-1:0]  out_node_reg;

    logic              cur_we, prev_we, cur_re, prev_re;
    logic [AW-1:0]     waddr, cur_raddr;
    logic [DATA_W-1:0] cur_wdata, prev_wdata, cur_rdata, prev_rdata;

    logic [DATA_W-1:0] alu_a, alu_b, alu_y;
    alu_ctrl_t         alu_ctrl;

    logic [DATA_W-1:0] c2;
    logic [DATA_W-1:0] new_val;
    logic [AW:0]       node_plus;
    logic              interior, last_node, load_in_range;

    fdss_ram #(.DEPTH(NODES), .WIDTH(DATA_W)) u_cur_ram (
        .aclk  (aclk),
        .we    (cur_we),
        .waddr (waddr),
        .wdata (cur_wdata),
        .re    (cur_re),
        .raddr (cur_raddr),
        .rdata (cur_rdata)
    );

    fdss_ram #(.DEPTH(NODES), .WIDTH(DATA_W)) u_prev_ram (
        .aclk  (aclk),
        .we    (prev_we),
        .waddr (waddr),
        .wdata (prev_wdata),
        .re    (prev_re),
        .raddr (node_reg),
        .rdata (prev_rdata)
    );

    fdss_alu u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .ctrl  (alu_ctrl),
        .shamt (damping_reg),
        .y     (alu_y)
    );

    assign c2            = {win_c_reg[DATA_W-2:0], 1'b0};
    assign node_plus     = {1'b0, node_reg} + (AW+1)'(1);
    assign interior      = (node_reg != '0) && (32'(node_reg) <= 32'(NODES - 3));
    assign last_node     = (node_reg == AW'(NODES - 1));
    assign load_in_range = (32'(s_node_index) < 32'(NODES));
    assign prod_next     = $signed(acc_reg) * $signed({1'b0, tension_reg});
    assign new_val       = interior ? alu_y : '0;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_sample  = m_sample_reg;

    always_comb begin
        state_next    = state_reg;
        node_next     = node_reg;
        win_l_next    = win_l_reg;
        win_c_next    = win_c_reg;
        acc_next      = acc_reg;
        dprev_next    = dprev_reg;
        sample_next   = sample_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_sample_next = m_sample_reg;
        cur_we        = 1'b0;
        prev_we       = 1'b0;
        cur_re        = 1'b0;
        prev_re       = 1'b0;
        waddr         = node_reg;
        cur_raddr     = node_plus[AW-1:0];
        cur_wdata     = '0;
        prev_wdata    = '0;
        alu_a         = acc_reg;
        alu_b         = acc_reg;
        alu_ctrl      = '{sub: 1'b0, shift: 1'b0};

        unique case (state_reg)
            ST_CLEAR: begin
                cur_we  = 1'b1;
                prev_we = 1'b1;
                if (last_node) begin
                    node_next  = '0;
                    state_next = ST_IDLE;
                end else begin
                    node_next = node_plus[AW-1:0];
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_action == ACT_TICK) begin
                        node_next   = '0;
                        sample_next = '0;
                        state_next  = ST_TSTART;
                    end else if (load_in_range) begin
                        // A pluck writes the node into both arrays.
                        cur_we     = 1'b1;
                        prev_we    = 1'b1;
                        waddr      = AW'(s_node_index);
                        cur_wdata  = s_node_value;
                        prev_wdata = s_node_value;
                    end
                end
            end
            ST_TSTART: begin
                cur_re     = 1'b1;
                cur_raddr  = '0;
                state_next = ST_TLOAD;
            end
            ST_TLOAD: begin
                win_c_next = cur_rdata;
                state_next = ST_READ;
            end
            ST_READ: begin
                // Fetch the right neighbor ahead of the in-place writes.
                cur_re     = (32'(node_plus) < 32'(NODES));
                prev_re    = 1'b1;
                state_next = interior ? ST_DPREV : ST_WRITE;
            end
            ST_DPREV: begin
                alu_a      = prev_rdata;
                alu_b      = prev_rdata;
                alu_ctrl   = '{sub: 1'b1, shift: 1'b1};
                dprev_next = alu_y;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                alu_a      = win_l_reg;
                alu_b      = cur_rdata;
                acc_next   = alu_y;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                alu_b      = c2;
                alu_ctrl   = '{sub: 1'b1, shift: 1'b0};
                acc_next   = alu_y;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_ADDC;
            end
            ST_ADDC: begin
                alu_a      = prod_reg[FRAC_BITS+DATA_W-1:FRAC_BITS];
                alu_b      = c2;
                acc_next   = alu_y;
                state_next = ST_SUBP;
            end
            ST_SUBP: begin
                alu_b      = dprev_reg;
                alu_ctrl   = '{sub: 1'b1, shift: 1'b0};
                acc_next   = alu_y;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                alu_ctrl   = '{sub: 1'b1, shift: 1'b1};
                cur_we     = 1'b1;
                prev_we    = 1'b1;
                cur_wdata  = new_val;
                prev_wdata = win_c_reg;
                if (32'(node_reg) == 32'(out_node_reg)) begin
                    sample_next = new_val;
                end
                win_l_next = win_c_reg;
                win_c_next = cur_rdata;
                if (last_node) begin
                    state_next = ST_FIN;
                end else begin
                    node_next  = node_plus[AW-1:0];
                    state_next = ST_READ;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = sample_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            node_reg     <= '0;
            m_valid_reg  <= 1'b0;
            tension_reg  <= TENSION_RST;
            damping_reg  <= DAMPING_RST;
            out_node_reg <= OUTNODE_RST;
        end else begin
            state_reg   <= state_next;
            node_reg    <= node_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_TENSION: tension_reg  <= cfg_data[RHO_W-1:0];
                    REG_DAMPING: damping_reg  <= cfg_data[SHIFT_W-1:0];
                    REG_OUTNODE: out_node_reg <= cfg_data[NODE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        win_l_reg    <= win_l_next;
        win_c_reg    <= win_c_next;
        acc_reg      <= acc_next;
        dprev_reg    <= dprev_next;
        sample_reg   <= sample_next;
        prod_reg     <= prod_next;
        m_sample_reg <= m_sample_next;
    end

endmodule

FILE: dv/tb_finite_difference_string_synth.sv
module tb_finite_difference_string_synth;
    timeunit 1ns;
    timeprecision 1ps;

    import fdss_pkg::*;

    localparam int CYCLE_LIMIT   = 2_500_000;
    localparam int SETTLE_CYCLES = 8 * NODES_DEF;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 103;
    localparam int HOLD_CYCLES   = 3000;
    localparam int REPORT_MAX    = 10;

    // Index 3 is not a register; writes to it must leave the block unchanged.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic                action;
        logic [NODE_W-1:0]   index;
        logic [DATA_W-1:0]   value;
        logic                known;
        logic [DATA_W-1:0]   sample;
    } stim_row_t;

    // Rows marked known carry a sample that is obvious by inspection: a silent string,
    // or energy that sits too far from the tap to reach it in one tick.
    localparam stim_row_t DIRECTED_ROWS [0:21] = '{
        '{ACT_TICK, 6'd0,  32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ACT_LOAD, 6'd0,  32'h7FFF_FFFF, 1'b0, 32'h0},
        '{ACT_LOAD, 6'd63, 32'h8000_0000, 1'b0, 32'h0},
        '{ACT_LOAD, 6'd62, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{ACT_LOAD, 6'd1,  32'h8000_0000, 1'b0, 32'h0},
        '{ACT_TICK, 6'd0,  32'h0000_0000, 1'b1, 32'h0000_0000},
        '{ACT_LOAD, 6'd32, 32'h7FFF_FFFF, 1'b0, 32'h0},
        '{ACT_LOAD, 6'd31, 32'h8000_0000, 1'b0, 32'h0},
        '{ACT_LOAD, 6'd33, 32'h8000_0000, 1'b0, 32'h0},
        '{ACT_TICK, 6'd0,  32'h0000_0000, 1'b0, 32'h0},
        '{ACT_TICK, 6'd63, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{ACT_LOAD, 6'd32, 32'h1000_0000, 1'b0, 32'h0},
        '{ACT_LOAD, 6'd31, 32'h0800_0000, 1'b0, 32'h0},
        '{ACT_LOAD, 6'd33, 32'h0800_0000, 1'b0, 32'h0},
        '{ACT_TICK, 6'd0,  32'h0000_0000, 1'b0, 32'h0},
        '{ACT_TICK, 6'd21, 32'h5555_AAAA, 1'b0, 32'h0},
        '{ACT_LOAD, 6'd61, 32'hFFFF_FFFF, 1'b0, 32'h0},
        '{ACT_LOAD, 6'd2,  32'h0000_0001, 1'b0, 32'h0},
        '{ACT_TICK, 6'd0,  32'h0000_0000, 1'b0, 32'h0},
        '{ACT_LOAD, 6'd32, 32'h0000_0000, 1'b0, 32'h0},
        '{ACT_TICK, 6'd0,  32'h0000_0000, 1'b0, 32'h0},
        '{ACT_TICK, 6'd0,  32'h0000_0000, 1'b0, 32'h0}
    };

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_action;
    logic [NODE_W-1:0]        s_node_index;
    logic signed [DATA_W-1:0] s_node_value;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [DATA_W-1:0] m_sample;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;

    finite_difference_string_synth u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_node_index (s_node_index),
        .s_node_value (s_node_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample     (m_sample),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // String state and register copies kept by the testbench.
    logic [DATA_W-1:0]  string_now [NODES_DEF];
    logic [DATA_W-1:0]  string_old [NODES_DEF];
    logic [RHO_W-1:0]   rho_model;
    logic [SHIFT_W-1:0] shift_model;
    logic [NODE_W-1:0]  tap_model;

    logic [DATA_W-1:0]  pending_samples [$];

    int  burst_left;
    bit  hold_request;
    int  loads_sent;
    int  ticks_sent;
    int  samples_checked;
    int  cfg_writes;
    int  mismatches;

    function automatic logic [DATA_W-1:0] damped(input logic [DATA_W-1:0] x);
        logic signed [DATA_W-1:0] sx;
        logic [DATA_W-1:0]        shifted;
        sx      = x;
        shifted = sx >>> shift_model;
        return x - shifted;
    endfunction

    // rho * diff is exact in 64 bits; the fix28 rescale rounds toward minus infinity.
    function automatic logic [DATA_W-1:0] rho_scaled(input logic [DATA_W-1:0] diff);
        longint     prod;
        logic [63:0] shifted;
        prod    = longint'($signed(diff)) * longint'(rho_model);
        shifted = prod >>> FRAC_BITS;
        return shifted[DATA_W-1:0];
    endfunction

    function automatic logic [DATA_W-1:0] tick_string();
        logic [DATA_W-1:0] fresh [NODES_DEF];
        logic [DATA_W-1:0] twice;
        logic [DATA_W-1:0] diff;
        int                i;
        for (i = 0; i < NODES_DEF; i++)
            fresh[i] = '0;
        for (i = 1; i + 2 < NODES_DEF; i++) begin
            twice    = string_now[i] << 1;
            diff     = string_now[i-1] + string_now[i+1] - twice;
            fresh[i] = damped(rho_scaled(diff) + twice - damped(string_old[i]));
        end
        string_old = string_now;
        string_now = fresh;
        return fresh[tap_model];
    endfunction

    function automatic logic [DATA_W-1:0] pluck_amplitude();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
            1: v = $urandom;
            2: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: v = $urandom_range(0, 2000) - 1000;
        endcase
        return v;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d samples still owed",
                 CYCLE_LIMIT, pending_samples.size());
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%t: %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    always @(posedge aclk) begin : check_samples
        logic [DATA_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            samples_checked++;
            if (pending_samples.size() == 0) begin
                report_mismatch("sample with no tick outstanding", 'x, m_sample);
            end else begin
                want = pending_samples.pop_front();
                if (m_sample !== want)
                    report_mismatch("sample", want, m_sample);
            end
        end
    end

    // Output side: ready is drawn at a random density from four levels; a hold request parks it low.
    initial begin : drive_ready
        int ready_pct;
        int cycle;
        ready_pct = 100;
        cycle     = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end
            if (cycle % 128 == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 30;
                    default: ready_pct = 5;
                endcase
            end
            cycle++;
            m_ready = ($urandom_range(0, 99) < ready_pct);
        end
    end

    task automatic idle_payload();
        s_action     = 1'($urandom);
        s_node_index = NODE_W'($urandom);
        s_node_value = $urandom;
    endtask

    task automatic offer_item(input logic act, input logic [NODE_W-1:0] idx,
                              input logic [DATA_W-1:0] val, input logic known,
                              input logic [DATA_W-1:0] typed);
        logic [DATA_W-1:0] predicted;
        @(negedge aclk);
        if (burst_left == 0) begin
            s_valid = 1'b0;
            idle_payload();
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
        end
        burst_left--;
        s_valid      = 1'b1;
        s_action     = act;
        s_node_index = idx;
        s_node_value = val;
        do @(posedge aclk); while (!s_ready);
        if (act == ACT_LOAD) begin
            string_now[idx] = val;
            string_old[idx] = val;
            loads_sent++;
        end else begin
            predicted = tick_string();
            pending_samples.push_back(known ? typed : predicted);
            ticks_sent++;
        end
    endtask

    // Stops offering, waits out every owed sample, then lets a full tick's time pass.
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        idle_payload();
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_TENSION: rho_model   = data[RHO_W-1:0];
            REG_DAMPING: shift_model = data[SHIFT_W-1:0];
            REG_OUTNODE: tap_model   = data[NODE_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Mostly plucks around the tap (or a random node if the tap is 0, 62 or 63) followed
    // by a run of ticks, with some stray loads and ticks mixed in.
    task automatic play_phase(input int count);
        int                sent;
        int                k;
        int                plucks;
        int                ticks;
        logic [NODE_W-1:0] center;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0) begin
                offer_item(1'($urandom), NODE_W'($urandom), $urandom, 1'b0, '0);
                sent++;
            end else begin
                center = (tap_model >= 1 && tap_model <= 61) ? tap_model : NODE_W'($urandom);
                plucks = $urandom_range(1, 6);
                for (k = 0; k < plucks; k++)
                    offer_item(ACT_LOAD, NODE_W'(center + $urandom_range(0, 16) - 8),
                               pluck_amplitude(), 1'b0, '0);
                ticks = $urandom_range(1, 8);
                for (k = 0; k < ticks; k++)
                    offer_item(ACT_TICK, NODE_W'($urandom), $urandom, 1'b0, '0);
                sent += plucks + ticks;
            end
        end
    endtask

    initial begin : stimulus
        int i;
        int p;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_action     = ACT_LOAD;
        s_node_index = '0;
        s_node_value = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_TENSION;
        cfg_data     = '0;
        hold_request = 1'b0;
        burst_left   = 0;
        rho_model    = TENSION_RST;
        shift_model  = DAMPING_RST;
        tap_model    = OUTNODE_RST;
        for (i = 0; i < NODES_DEF; i++) begin
            string_now[i] = '0;
            string_old[i] = '0;
        end
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;

        for (i = 0; i < $size(DIRECTED_ROWS); i++)
            offer_item(DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].index,
                       DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].known,
                       DIRECTED_ROWS[i].sample);
        drain();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    write_reg(REG_TENSION, 32'h1000_0000);
                    write_reg(REG_DAMPING, 32'd1);
                    write_reg(REG_OUTNODE, 32'd1);
                end
                1: begin
                    write_reg(REG_TENSION, 32'd0);
                    write_reg(REG_DAMPING, 32'd31);
                    write_reg(REG_OUTNODE, 32'd63);
                end
                2: begin
                    // Upper bits beyond each register's width are junk and must be dropped.
                    write_reg(REG_TENSION, 32'hFFFF_FFFF);
                    write_reg(REG_DAMPING, 32'hFFFF_FFE0);
                    write_reg(REG_OUTNODE, 32'hFFFF_FFFD);
                end
                3: begin
                    write_reg(REG_TENSION, {3'b000, TENSION_RST});
                    write_reg(REG_DAMPING, {27'd0, DAMPING_RST});
                    write_reg(REG_OUTNODE, 32'd0);
                    write_reg(REG_SPARE, $urandom);
                end
                4: begin
                    write_reg(REG_TENSION, {3'($urandom_range(0, 7)), 29'($urandom)});
                    write_reg(REG_DAMPING, 32'd2);
                    write_reg(REG_OUTNODE, 32'd62);
                end
                default: begin
                    write_reg(REG_TENSION,
                              {3'($urandom_range(0, 7)),
                               29'($urandom_range(0, 32'h1000_0000))});
                    write_reg(REG_DAMPING, {27'($urandom), 5'($urandom_range(1, 31))});
                    write_reg(REG_OUTNODE, {26'($urandom), 6'($urandom_range(1, 61))});
                end
            endcase
            // Park the output side for a while so the block backs up into its input.
            if (p == 5)
                hold_request = 1'b1;
            play_phase(PHASE_ITEMS);
            drain();
        end

        $display("covered %0d loads and %0d ticks across %0d register settings (%0d writes)",
                 loads_sent, ticks_sent, PHASES + 1, cfg_writes);
        $display("%0d samples checked, including a long output stall and idle pauses",
                 samples_checked);
        if (mismatches == 0 && pending_samples.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d samples never arrived",
                     mismatches, pending_samples.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/fdss_pkg.sv
rtl/fdss_ram.sv
rtl/fdss_alu.sv
rtl/finite_difference_string_synth.sv
dv/tb_finite_difference_string_synth.sv
